@@ sv/lwpc_pkg.sv @@
package lwpc_pkg;

   localparam int PAGE_FIELD_BITS = 24;
   localparam int SLOT_FIELD_BITS = 4;

   localparam logic [1:0] OP_ACCESS = 2'd0;
   localparam logic [1:0] OP_MARK   = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   typedef struct packed {
      logic [1:0]                 operation;
      logic [PAGE_FIELD_BITS-1:0] page_id;
   } req_type;

   typedef struct packed {
      logic [SLOT_FIELD_BITS-1:0] slot;
      logic                       hit;
      logic                       write_back;
      logic [PAGE_FIELD_BITS-1:0] write_back_page;
      logic                       fetch;
      logic                       last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic look;
      logic apply;
      logic flush_step;
      logic flush_final;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] operation;
      logic       walk_done;
   } status_type;

endpackage

@@ sv/lwpc_datapath.sv @@
module lwpc_datapath #(
   parameter int SLOTS            = 16,
   parameter int PAGE_NUMBER_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lwpc_pkg::req_type    req,
   input  lwpc_pkg::cmd_type    cmd,
   output lwpc_pkg::status_type status,
   output logic                 rsp_strobe,
   output lwpc_pkg::rsp_type    rsp
);
   import lwpc_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int PW = (PAGE_NUMBER_BITS < PAGE_FIELD_BITS) ? PAGE_NUMBER_BITS
                                                            : PAGE_FIELD_BITS;

   function automatic logic [SW-1:0] first_set(input logic [SLOTS-1:0] v);
      logic [SW-1:0] idx;
      idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (v[i]) idx = SW'(i);
      end
      return idx;
   endfunction

   function automatic logic [SLOT_FIELD_BITS-1:0] slot_field(input logic [SW-1:0] idx);
      logic [SW+SLOT_FIELD_BITS-1:0] w;
      w = {{SLOT_FIELD_BITS{1'b0}}, idx};
      return w[SLOT_FIELD_BITS-1:0];
   endfunction

   function automatic logic [PAGE_FIELD_BITS-1:0] page_field(input logic [PW-1:0] pg);
      logic [PW+PAGE_FIELD_BITS-1:0] w;
      w = {{PAGE_FIELD_BITS{1'b0}}, pg};
      return w[PAGE_FIELD_BITS-1:0];
   endfunction

   req_type          req_ff;
   logic [PW-1:0]    page_ff [SLOTS];
   logic [SLOTS-1:0] dirty_ff, dirty_in;
   logic [SW-1:0]    rank_ff [SLOTS];
   logic [SW-1:0]    rank_in [SLOTS];
   logic [CW-1:0]    used_ff, used_in;
   logic [SLOTS-1:0] match_ff, match_in;
   logic [SLOTS-1:0] victim_ff, victim_in;
   logic [CW-1:0]    walk_ff, walk_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [SW-1:0]    pend_slot_ff, pend_slot_in;
   logic [PW-1:0]    pend_page_ff, pend_page_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic [SLOTS-1:0] valid;
   logic [SLOTS-1:0] walk_match;
   logic [PW-1:0]    req_page;
   logic [SW-1:0]    hit_idx, victim_idx, walk_idx, rd_addr;
   logic [PW-1:0]    rd_page;
   logic             hit_any, full;
   logic [CW-1:0]    used_m1;
   logic             page_we;
   logic [SW-1:0]    page_wa;
   logic             promote_en;
   logic [SW-1:0]    promote_slot, promote_rank;

   assign req_page   = req_ff.page_id[PW-1:0];
   assign hit_idx    = first_set(match_ff);
   assign hit_any    = |match_ff;
   assign victim_idx = first_set(victim_ff);
   assign walk_idx   = first_set(walk_match);
   assign full       = (used_ff == CW'(SLOTS));
   assign used_m1    = used_ff - CW'(1);
   assign rd_addr    = cmd.apply ? victim_idx : walk_idx;
   assign rd_page    = page_ff[rd_addr];

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         valid[i]      = CW'(i) < used_ff;
         match_in[i]   = valid[i] && (page_ff[i] == req_page);
         victim_in[i]  = valid[i] && (rank_ff[i] == '0);
         walk_match[i] = valid[i] && (rank_ff[i] == walk_ff[SW-1:0]);
      end
   end

   always_comb begin
      dirty_in      = dirty_ff;
      used_in       = used_ff;
      walk_in       = walk_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_page_in  = pend_page_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      page_we       = 1'b0;
      page_wa       = victim_idx;
      promote_en    = 1'b0;
      promote_slot  = hit_idx;
      for (int i = 0; i < SLOTS; i++) rank_in[i] = rank_ff[i];

      if (cmd.look) begin
         walk_in       = '0;
         pend_valid_in = 1'b0;
      end

      if (cmd.apply) begin
         case (req_ff.operation)
            OP_ACCESS: begin
               rsp_strobe_in = 1'b1;
               rsp_in.last   = 1'b1;
               if (hit_any) begin
                  promote_en  = 1'b1;
                  rsp_in.slot = slot_field(hit_idx);
                  rsp_in.hit  = 1'b1;
               end else if (!full) begin
                  page_we                    = 1'b1;
                  page_wa                    = used_ff[SW-1:0];
                  dirty_in[used_ff[SW-1:0]]  = 1'b0;
                  rank_in[used_ff[SW-1:0]]   = used_ff[SW-1:0];
                  used_in                    = used_ff + CW'(1);
                  rsp_in.slot                = slot_field(used_ff[SW-1:0]);
                  rsp_in.fetch               = 1'b1;
               end else begin
                  page_we              = 1'b1;
                  dirty_in[victim_idx] = 1'b0;
                  promote_en           = 1'b1;
                  promote_slot         = victim_idx;
                  rsp_in.slot          = slot_field(victim_idx);
                  rsp_in.write_back    = dirty_ff[victim_idx];
                  rsp_in.write_back_page = dirty_ff[victim_idx] ? page_field(rd_page) : '0;
                  rsp_in.fetch         = 1'b1;
               end
            end
            OP_MARK: begin
               rsp_strobe_in = 1'b1;
               rsp_in.last   = 1'b1;
               if (hit_any) begin
                  dirty_in[hit_idx] = 1'b1;
                  rsp_in.slot       = slot_field(hit_idx);
                  rsp_in.hit        = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.flush_step) begin
         walk_in = walk_ff + CW'(1);
         if (dirty_ff[walk_idx]) begin
            dirty_in[walk_idx] = 1'b0;
            if (pend_valid_ff) begin
               rsp_strobe_in          = 1'b1;
               rsp_in.slot            = slot_field(pend_slot_ff);
               rsp_in.write_back      = 1'b1;
               rsp_in.write_back_page = page_field(pend_page_ff);
            end
            pend_valid_in = 1'b1;
            pend_slot_in  = walk_idx;
            pend_page_in  = rd_page;
         end
      end

      if (cmd.flush_final && pend_valid_ff) begin
         rsp_strobe_in          = 1'b1;
         rsp_in.slot            = slot_field(pend_slot_ff);
         rsp_in.write_back      = 1'b1;
         rsp_in.write_back_page = page_field(pend_page_ff);
         rsp_in.last            = 1'b1;
         pend_valid_in          = 1'b0;
      end

      // move one slot to most recent, close the gap above its old rank
      promote_rank = rank_ff[promote_slot];
      if (promote_en) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (valid[i] && (rank_ff[i] > promote_rank)) rank_in[i] = rank_ff[i] - SW'(1);
         end
         rank_in[promote_slot] = used_m1[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req;
      if (page_we) page_ff[page_wa] <= req_page;
      if (rsp_strobe_in) rsp_ff <= rsp_in;
      pend_slot_ff <= pend_slot_in;
      pend_page_ff <= pend_page_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff      <= '0;
         used_ff       <= '0;
         match_ff      <= '0;
         victim_ff     <= '0;
         walk_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) rank_ff[i] <= '0;
      end else begin
         dirty_ff      <= dirty_in;
         used_ff       <= used_in;
         walk_ff       <= walk_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         for (int i = 0; i < SLOTS; i++) rank_ff[i] <= rank_in[i];
         if (cmd.look) begin
            match_ff  <= match_in;
            victim_ff <= victim_in;
         end
      end
   end

   assign status.operation = req_ff.operation;
   assign status.walk_done = (walk_ff >= used_ff);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp              = rsp_ff;

`ifndef ASSERT_OFF
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_ff))
      else $error("page resident in more than one slot");
   a_victim_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(victim_ff))
      else $error("more than one least recent slot");
   a_dirty_in_use: assert property (@(posedge clock) disable iff (reset)
      (dirty_ff & ~valid) == '0)
      else $error("dirty bit on a free slot");
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_final && pend_valid_ff |=> rsp_strobe_ff && rsp_ff.last)
      else $error("flush ended without a final transfer");
`endif

endmodule

@@ sv/lwpc_controller.sv @@
module lwpc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  lwpc_pkg::status_type status,
   output logic                 busy,
   output lwpc_pkg::cmd_type    cmd
);
   import lwpc_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOOK  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign busy   = !((state_ff == ST_IDLE) ||
                     ((state_ff == ST_APPLY) && (status.operation != OP_FLUSH)));
   assign accept = start && !busy;

   always_comb begin
      cmd          = '0;
      cmd.load_req = accept;
      state_in     = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            if (status.operation == OP_FLUSH) state_in = ST_FLUSH;
            else if (accept)                  state_in = ST_LOOK;
            else                              state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (status.walk_done) begin
               cmd.flush_final = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.flush_step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

`ifndef ASSERT_OFF
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOK)
      else $error("accepted request did not start a lookup");
   a_flush_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> busy && !cmd.load_req)
      else $error("request taken during flush walk");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.look, cmd.apply, cmd.flush_step, cmd.flush_final}))
      else $error("conflicting datapath commands");
`endif

endmodule

@@ sv/lru_writeback_page_cache_control_core.sv @@
// Page cache tag and replacement controller, fully associative, LRU, write-back.
// Request channel: drive req (operation, page_id) and raise start; the
// request transfers at the clock edge where start is high and busy is low.
// Result channel: each result sits on rsp for one cycle with rsp_strobe high;
// the receiver must take it then, as there is no back-pressure.
// Access and mark: exactly one result, after the lookup cycle and the update
// cycle, in the registered result. busy drops in the update cycle, so a new
// request can transfer there, before the previous result shows on rsp; the
// parallel page compare is registered in the lookup cycle.
// Flush: after lookup and update, the walk visits one recency rank per cycle,
// least recent first, over all occupied slots, then one closing cycle; busy
// stays high through the closing cycle. A dirty slot's write-back is held
// until the walk reaches the next dirty slot or the closing cycle, so the
// final one can carry last; it shows on rsp the cycle after. No dirty slot,
// no result. Unused operation code 3 takes the access timing and yields nothing.
// Reset (synchronous, active high) empties the cache: no slot in use, all
// dirty bits and ranks clear. Page storage needs no clearing pass.
module lru_writeback_page_cache_control_core #(
   parameter int SLOTS            = 16,
   parameter int PAGE_NUMBER_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lwpc_pkg::req_type req,
   output logic              rsp_strobe,
   output lwpc_pkg::rsp_type rsp
);
   import lwpc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequence lookup, update and the flush walk
   lwpc_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // hold tags, dirty bits and ranks; drive the result register
   lwpc_datapath #(
      .SLOTS            (SLOTS),
      .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

endmodule
